### src/brf_pkg.sv
// brf_pkg: sizes, request codes and configuration register indexes for the
// byte ring fifo with sync hunt. No dependencies.
package brf_pkg;

    localparam int DEPTH      = 2048;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int PTR_W      = ADDR_W + 1;
    localparam int DATA_W     = 8;
    localparam int MODE_W     = 3;
    localparam int AMT_W      = 12;
    localparam int LVL_W      = 12;
    localparam int LOG_W      = 4;
    localparam int SYNC_W     = 32;
    localparam int CODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH  = 3'd0,
        MODE_POP   = 3'd1,
        MODE_PEEK  = 3'd2,
        MODE_SKIP  = 3'd3,
        MODE_FLUSH = 3'd4,
        MODE_HUNT  = 3'd5
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAP_LOG2  = 2'd0,
        CFG_SYNC_VAL  = 2'd1,
        CFG_SYNC_CODE = 2'd2,
        CFG_SYNC_BE   = 2'd3
    } t_cfg_idx;

    typedef enum logic [CODE_W-1:0] {
        SYNC_ONE  = 2'd0,
        SYNC_TWO  = 2'd1,
        SYNC_FOUR = 2'd2
    } t_sync_code;

endpackage

### src/brf_in_if.sv
// brf_in_if: request channel (valid/ready plus mode, data_in, amount).
// Depends on brf_pkg.
interface brf_in_if import brf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] data_in;
    logic [AMT_W-1:0]  amount;

    modport source (output valid, output mode, output data_in, output amount, input ready);
    modport sink   (input valid, input mode, input data_in, input amount, output ready);
endinterface

### src/brf_out_if.sv
// brf_out_if: response channel (valid/ready plus data_out, ok, level).
// Depends on brf_pkg.
interface brf_out_if import brf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_out;
    logic              ok;
    logic [LVL_W-1:0]  level;

    modport source (output valid, output data_out, output ok, output level, input ready);
    modport sink   (input valid, input data_out, input ok, input level, output ready);
endinterface

### src/brf_ram.sv
// brf_ram: generic single write port, single read port ram with registered
// read data. No dependencies.
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/byte_ring_fifo_with_sync_hunt.sv
// byte_ring_fifo_with_sync_hunt: byte fifo on a power-of-two ring with a
// sync header hunt. Depends on brf_pkg, brf_in_if, brf_out_if, brf_ram.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+---------------------------
//  i_req    | in  | valid / ready | mode, data_in, amount
//  o_rsp    | out | valid / ready | data_out, ok, level
//  i_cfg_*  | in  | write enable  | index, data (no read-back)
//
// one request at a time: push, skip, flush and unused modes go from exec
// straight to out; pop and peek read the ram (rd, rdcap) with registered data.
// hunt reads every candidate header, w = 1, 2 or 4 bytes, byte by byte
// through the single ram port, one header position after another.
// reset (sync, active low) empties the queue; no clearing pass is needed.
// a stalled response sits in the output register; the next request is taken
// meanwhile and waits for it only when its own response is ready.
module byte_ring_fifo_with_sync_hunt import brf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    brf_in_if.sink                i_req,
    brf_out_if.source             o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RD,
        S_RDCAP,
        S_HCHK,
        S_HRD,
        S_HCAP,
        S_HCMP,
        S_OUT
    } t_state;

    t_state             r_state;
    logic [MODE_W-1:0]  r_mode;
    logic [DATA_W-1:0]  r_din;
    logic [AMT_W-1:0]   r_amount;
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [PTR_W-1:0]   r_off;
    logic [1:0]         r_cnt;
    logic [SYNC_W-1:0]  r_hdr;
    logic [DATA_W-1:0]  r_dout;
    logic               r_ok;
    logic               r_hfail;
    logic               r_ov;
    logic [DATA_W-1:0]  r_out_data;
    logic               r_out_ok;
    logic [LVL_W-1:0]   r_out_lvl;
    logic [LOG_W-1:0]   r_cap_lg;
    logic [SYNC_W-1:0]  r_sync_val;
    logic [CODE_W-1:0]  r_sync_code;
    logic               r_sync_be;

    logic [LOG_W-1:0]   lg_eff;
    logic [ADDR_W-1:0]  cap_mask;
    logic [PTR_W-1:0]   cap;
    logic [PTR_W-1:0]   level;
    logic [PTR_W-1:0]   skip_n;
    logic [2:0]         hdr_w;
    logic [SYNC_W-1:0]  want;
    logic               hdr_last;
    logic [PTR_W-1:0]   rd_ptr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               ram_we;
    logic [DATA_W-1:0]  rd_data;
    logic               out_load;

    always_comb begin
        if (r_cap_lg == '0) begin
            lg_eff = LOG_W'(1);
        end else if (r_cap_lg > LOG_W'(ADDR_W)) begin
            lg_eff = LOG_W'(ADDR_W);
        end else begin
            lg_eff = r_cap_lg;
        end
        cap_mask = ADDR_W'((PTR_W'(1) << lg_eff) - PTR_W'(1));
        cap      = PTR_W'(cap_mask) + PTR_W'(1);
        level    = r_wp - r_rp;
        skip_n   = (PTR_W'(r_amount) > level) ? level : PTR_W'(r_amount);

        // header width code three behaves as four bytes
        unique case (r_sync_code)
            SYNC_ONE: begin
                hdr_w = 3'd1;
                want  = {24'd0, r_sync_val[7:0]};
            end
            SYNC_TWO: begin
                hdr_w = 3'd2;
                want  = {16'd0, r_sync_val[15:0]};
            end
            default: begin
                hdr_w = 3'd4;
                want  = r_sync_val;
            end
        endcase
        hdr_last = (r_cnt == 2'(hdr_w - 3'd1));

        rd_ptr  = r_rp + r_off;
        rd_addr = rd_ptr[ADDR_W-1:0] & cap_mask;
        wr_addr = r_wp[ADDR_W-1:0] & cap_mask;
        ram_we  = (r_state == S_EXEC) && (r_mode == MODE_PUSH) && (level < cap);
        // output register free, or its response leaves at this edge
        out_load = (r_state == S_OUT) && (!r_ov || o_rsp.ready);
    end

    brf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata (r_din),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_ov        <= 1'b0;
            r_cap_lg    <= LOG_W'(11);
            r_sync_val  <= '0;
            r_sync_code <= SYNC_ONE;
            r_sync_be   <= 1'b0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_mode   <= i_req.mode;
                        r_din    <= i_req.data_in;
                        r_amount <= i_req.amount;
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_dout  <= '0;
                    r_hfail <= 1'b0;
                    r_ok    <= (r_mode == MODE_PUSH) && (level < cap);
                    r_off   <= (r_mode == MODE_PEEK) ? PTR_W'(r_amount) : '0;
                    case (r_mode)
                        MODE_PUSH: begin
                            if (level < cap) begin
                                r_wp <= r_wp + PTR_W'(1);
                            end
                            r_state <= S_OUT;
                        end
                        MODE_POP: begin
                            r_state <= (level != '0) ? S_RD : S_OUT;
                        end
                        MODE_PEEK: begin
                            r_state <= (PTR_W'(r_amount) < level) ? S_RD : S_OUT;
                        end
                        MODE_SKIP: begin
                            r_rp    <= r_rp + skip_n;
                            r_state <= S_OUT;
                        end
                        MODE_FLUSH: begin
                            r_wp    <= '0;
                            r_rp    <= '0;
                            r_state <= S_OUT;
                        end
                        MODE_HUNT: begin
                            r_state <= S_HCHK;
                        end
                        default: begin
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_RD: begin
                    r_state <= S_RDCAP;
                end
                S_RDCAP: begin
                    r_dout <= rd_data;
                    r_ok   <= 1'b1;
                    if (r_mode == MODE_POP) begin
                        r_rp <= r_rp + PTR_W'(1);
                    end
                    r_state <= S_OUT;
                end
                S_HCHK: begin
                    // too few bytes left for a header: give up, keep them queued
                    if (level < PTR_W'(hdr_w)) begin
                        r_hfail <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_cnt   <= '0;
                        r_off   <= '0;
                        r_hdr   <= '0;
                        r_state <= S_HRD;
                    end
                end
                S_HRD: begin
                    r_state <= S_HCAP;
                end
                S_HCAP: begin
                    if (r_sync_be) begin
                        r_hdr <= {r_hdr[SYNC_W-DATA_W-1:0], rd_data};
                    end else begin
                        r_hdr[{r_cnt, 3'b000} +: DATA_W] <= rd_data;
                    end
                    if (hdr_last) begin
                        r_state <= S_HCMP;
                    end else begin
                        r_cnt   <= r_cnt + 2'd1;
                        r_off   <= r_off + PTR_W'(1);
                        r_state <= S_HRD;
                    end
                end
                S_HCMP: begin
                    if (r_hdr == want) begin
                        r_ok    <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_rp    <= r_rp + PTR_W'(1);
                        r_state <= S_HCHK;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_data <= r_dout;
                        r_out_ok   <= r_ok;
                        r_out_lvl  <= r_hfail ? '0 : LVL_W'(level);
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // configuration must arrive only while idle; the block itself does not enforce it
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CAP_LOG2: begin
                        r_cap_lg <= i_cfg_data[LOG_W-1:0];
                        r_wp     <= '0;
                        r_rp     <= '0;
                    end
                    CFG_SYNC_VAL:  r_sync_val  <= i_cfg_data[SYNC_W-1:0];
                    CFG_SYNC_CODE: r_sync_code <= i_cfg_data[CODE_W-1:0];
                    CFG_SYNC_BE:   r_sync_be   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_ov;
    assign o_rsp.data_out = r_out_data;
    assign o_rsp.ok       = r_out_ok;
    assign o_rsp.level    = r_out_lvl;

endmodule

### src/brf_checker.sv
// brf_checker: port-level assertions for byte_ring_fifo_with_sync_hunt and
// the bind that attaches them. Depends on brf_pkg.
module brf_checker import brf_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DATA_W-1:0] i_out_data,
    input logic              i_out_ok,
    input logic [LVL_W-1:0]  i_out_level
);

    // one request in flight: ready drops right after a request is taken
    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken while another is in flight");

    // a response without ok (failed, or skip, flush or unused mode) never carries a data byte
    a_data_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ok) |-> (i_out_data == '0))
        else $error("data byte on a response without ok");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_level <= LVL_W'(DEPTH)))
        else $error("reported level above ring depth");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("stalled response withdrawn");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("response pending or not ready after reset");

endmodule

bind byte_ring_fifo_with_sync_hunt brf_checker u_brf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_data  (o_rsp.data_out),
    .i_out_ok    (o_rsp.ok),
    .i_out_level (o_rsp.level)
);
